### src/pse_pkg.sv
// Shared constants and types for the postfix stack evaluator.
// Used by pse_stack, pse_alu and postfix_stack_evaluator_top; depends on nothing.
package pse_pkg;

  localparam int STACK_DEPTH_DEF = 128;
  localparam int DATA_W = 32;

  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_APPLY  = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_POW = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OVERFLOW  = 3'd1;
  localparam logic [2:0] ST_UNDERFLOW = 3'd2;
  localparam logic [2:0] ST_DIVZERO   = 3'd3;
  localparam logic [2:0] ST_INVALID   = 3'd4;

  typedef enum logic [1:0] {
    ALU_MUL = 2'd0,
    ALU_DIV = 2'd1,
    ALU_POW = 2'd2
  } alu_kind_t;

  typedef struct packed {
    logic              start;
    alu_kind_t         kind;
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

endpackage

### src/pse_stack.sv
// Operand stack storage: one write port and one registered read port.
// Depends on pse_pkg for the data width.
module pse_stack #(
  parameter int DEPTH = pse_pkg::STACK_DEPTH_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [pse_pkg::DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [pse_pkg::DATA_W-1:0] rd_data
);
  import pse_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### src/pse_alu.sv
// Iterative arithmetic unit: one 32x32 multiplier for multiply and
// square-and-multiply power, and a restoring divider one bit per cycle.
// Depends on pse_pkg for the request and response types.
module pse_alu (
  input  logic              clk,
  input  logic              rst,
  input  pse_pkg::alu_req_t req,
  output pse_pkg::alu_rsp_t rsp
);
  import pse_pkg::*;

  typedef enum logic [5:0] {
    A_IDLE  = 6'b000001,
    A_MUL   = 6'b000010,
    A_POW_M = 6'b000100,
    A_POW_S = 6'b001000,
    A_DIV   = 6'b010000,
    A_DONE  = 6'b100000
  } alu_state_t;

  alu_state_t state;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] base;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] rem;
  logic [4:0]        step;
  logic              neg;

  logic [DATA_W-1:0] mul_a;
  logic [DATA_W-1:0] prod;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;
  logic              fits;
  logic [DATA_W-1:0] rem_new;
  logic [DATA_W-1:0] quo_new;

  // The same multiplier serves acc*base and base*base.
  assign mul_a = (state == A_POW_S) ? base : acc;
  assign prod  = DATA_W'(mul_a * base);

  assign rem_sh  = {rem, quo[DATA_W-1]};
  assign diff    = rem_sh - {1'b0, base};
  assign fits    = !diff[DATA_W];
  assign rem_new = fits ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
  assign quo_new = {quo[DATA_W-2:0], fits};

  assign rsp.done   = (state == A_DONE);
  assign rsp.result = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
    end else begin
      case (state)
        A_IDLE: begin
          if (req.start) begin
            case (req.kind)
              ALU_MUL: begin
                acc   <= req.lhs;
                base  <= req.rhs;
                state <= A_MUL;
              end
              ALU_DIV: begin
                quo   <= req.lhs[DATA_W-1] ? DATA_W'(0 - req.lhs) : req.lhs;
                base  <= req.rhs[DATA_W-1] ? DATA_W'(0 - req.rhs) : req.rhs;
                rem   <= '0;
                step  <= '0;
                neg   <= req.lhs[DATA_W-1] ^ req.rhs[DATA_W-1];
                state <= A_DIV;
              end
              default: begin
                acc <= DATA_W'(1);
                // A negative or zero exponent gives one.
                if (req.rhs[DATA_W-1] || (req.rhs == '0)) begin
                  state <= A_DONE;
                end else begin
                  base  <= req.lhs;
                  quo   <= req.rhs;
                  state <= A_POW_M;
                end
              end
            endcase
          end
        end
        A_MUL: begin
          acc   <= prod;
          state <= A_DONE;
        end
        A_POW_M: begin
          if (quo[0]) begin
            acc <= prod;
          end
          state <= A_POW_S;
        end
        A_POW_S: begin
          base <= prod;
          quo  <= quo >> 1;
          if (quo[DATA_W-1:1] == '0) begin
            state <= A_DONE;
          end else begin
            state <= A_POW_M;
          end
        end
        A_DIV: begin
          rem  <= rem_new;
          quo  <= quo_new;
          step <= step + 5'd1;
          if (step == 5'd31) begin
            acc   <= neg ? DATA_W'(0 - quo_new) : quo_new;
            state <= A_DONE;
          end
        end
        A_DONE: begin
          state <= A_IDLE;
        end
        default: begin
          state <= A_IDLE;
        end
      endcase
    end
  end

endmodule

### src/postfix_stack_evaluator_top.sv
// Postfix stack evaluator: one result item for every input item.
// Push, finish and unused commands answer from S_IDLE; add, subtract and invalid operators
// from S_LOAD; divide by zero from S_RELOAD; multiply, divide (one quotient bit per cycle)
// and power wait in S_CALC for the ALU; power squares and multiplies in turn on the single
// multiplier. A new item is taken once the previous result is registered and not stalled.
// Reset clears the stack count, the abort flag and the controls; stack memory is not cleared.
module postfix_stack_evaluator_top #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  cmd,
  input  logic [30:0]                 number,
  input  logic [2:0]                  op,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [pse_pkg::DATA_W-1:0] value,
  output logic [2:0]                  status,
  output logic                        done_res
);
  import pse_pkg::*;

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LOAD   = 4'b0010,
    S_CALC   = 4'b0100,
    S_RELOAD = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              aborted, aborted_next;
  logic [DATA_W-1:0] top, top_next;
  logic [DATA_W-1:0] r_val, r_val_next;
  logic              under, under_next;
  logic [2:0]        op_q, op_q_next;

  logic              accept;
  logic              emit;
  logic [DATA_W-1:0] em_value;
  logic [2:0]        em_status;
  logic              em_done;
  logic              push_res;
  logic [DATA_W-1:0] res;
  logic [2:0]        res_status;
  logic [DATA_W-1:0] l_val;
  logic [CNT_W-1:0]  cnt_m1, cnt_m2;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [DATA_W-1:0] rd_data;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  pse_stack #(.DEPTH(STACK_DEPTH)) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pse_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  // On acceptance the read fetches the left operand; afterwards count is
  // already popped and the read fetches the new top for an abort.
  assign cnt_m1  = count - CNT_W'(1);
  assign cnt_m2  = count - CNT_W'(2);
  assign rd_addr = (state == S_IDLE) ? cnt_m2[ADDR_W-1:0] : cnt_m1[ADDR_W-1:0];
  assign l_val   = under ? '0 : rd_data;

  always_comb begin
    state_next   = state;
    count_next   = count;
    aborted_next = aborted;
    top_next     = top;
    r_val_next   = r_val;
    under_next   = under;
    op_q_next    = op_q;
    emit         = 1'b0;
    em_value     = '0;
    em_status    = ST_OK;
    em_done      = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = count[ADDR_W-1:0];
    wr_data      = {1'b0, number};
    push_res     = 1'b0;
    res          = '0;
    res_status   = under ? ST_UNDERFLOW : ST_OK;
    alu_req.start = 1'b0;
    alu_req.kind  = ALU_MUL;
    alu_req.lhs   = l_val;
    alu_req.rhs   = r_val;

    case (state)
      S_IDLE: begin
        if (accept) begin
          emit = 1'b1;
          if (cmd == CMD_FINISH) begin
            em_done = 1'b1;
            if (aborted) begin
              em_status = ST_DIVZERO;
            end else if (count == '0) begin
              em_status = ST_UNDERFLOW;
            end else begin
              em_value = top;
            end
            count_next   = '0;
            aborted_next = 1'b0;
          end else if (cmd == CMD_UNUSED) begin
            em_value = (count != '0) ? top : '0;
          end else if (aborted) begin
            em_status = ST_DIVZERO;
          end else if (cmd == CMD_PUSH) begin
            if (count < CNT_W'(STACK_DEPTH)) begin
              wr_en      = 1'b1;
              top_next   = {1'b0, number};
              count_next = count + CNT_W'(1);
              em_value   = {1'b0, number};
            end else begin
              em_value  = top;
              em_status = ST_OVERFLOW;
            end
          end else begin
            emit       = 1'b0;
            r_val_next = (count != '0) ? top : '0;
            under_next = (count < CNT_W'(2));
            op_q_next  = op;
            count_next = (count >= CNT_W'(2)) ? cnt_m2 : '0;
            state_next = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        case (op_q)
          OP_ADD: begin
            push_res = 1'b1;
            res      = l_val + r_val;
          end
          OP_SUB: begin
            push_res = 1'b1;
            res      = l_val - r_val;
          end
          OP_MUL: begin
            alu_req.start = 1'b1;
            alu_req.kind  = ALU_MUL;
            state_next    = S_CALC;
          end
          OP_DIV: begin
            if (r_val == '0) begin
              aborted_next = 1'b1;
              state_next   = S_RELOAD;
            end else begin
              alu_req.start = 1'b1;
              alu_req.kind  = ALU_DIV;
              state_next    = S_CALC;
            end
          end
          OP_POW: begin
            alu_req.start = 1'b1;
            alu_req.kind  = ALU_POW;
            state_next    = S_CALC;
          end
          default: begin
            push_res   = 1'b1;
            res_status = ST_INVALID;
          end
        endcase
      end
      S_CALC: begin
        if (alu_rsp.done) begin
          push_res = 1'b1;
          res      = alu_rsp.result;
        end
      end
      S_RELOAD: begin
        // The stack stays as popped, so the cached top must follow it.
        top_next   = rd_data;
        emit       = 1'b1;
        em_status  = ST_DIVZERO;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Popping never leaves the stack full, so pushing the result always fits.
    if (push_res) begin
      wr_en      = 1'b1;
      wr_data    = res;
      top_next   = res;
      count_next = count + CNT_W'(1);
      emit       = 1'b1;
      em_value   = res;
      em_status  = res_status;
      state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      aborted   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      aborted <= aborted_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top   <= top_next;
    r_val <= r_val_next;
    under <= under_next;
    op_q  <= op_q_next;
    if (emit) begin
      value    <= em_value;
      status   <= em_status;
      done_res <= em_done;
    end
  end

endmodule
